>>> src/pcmd_pkg.sv
// Package for the PCM line deinterleaver.
// Holds the geometry constants, word and control types, and the lane delay function.
// No dependencies.
package pcmd_pkg;

  localparam int LineShift = 16;
  localparam int Columns   = 8;
  localparam int WordBits  = 14;

  // Longest column delay in lines (column 0)
  localparam int MaxDelay  = LineShift * (Columns - 1);
  localparam int AddrW     = $clog2(MaxDelay);
  localparam int CntW      = $clog2(MaxDelay + 1);

  typedef logic [WordBits-1:0] word_t;
  typedef logic [CntW-1:0]     cnt_t;

  typedef struct packed {
    logic accept;
    cnt_t fill;
  } lane_ctrl_t;

  // Delay of column c in lines
  function automatic cnt_t lane_depth(int c);
    return CntW'(LineShift * (Columns - 1 - c));
  endfunction

endpackage

>>> src/pcm_line_deinterleaver.sv
// PCM line deinterleaver top level: per-column delay lanes and the output stage.
// Depends on pcmd_pkg and pcmd_lane.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  input    | in_valid_i / in_ready_o  | word_0_i..word_7_i, padding_i
//  output   | out_valid_o / out_ready_i| out_0_o..out_7_o
//
// One line per cycle sustained while the output is not stalled; each line taken passes
// the RAM read register, then the output register.
// Each column but the last has its own RAM ring, read and written at one address per line.
// Reset clears pointers and the fill count; the RAMs are not swept, entries
// never written since reset read as zero through the fill count.
// A stalled output holds both stages; input is still taken while a stage is free.
module pcm_line_deinterleaver (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pcmd_pkg::word_t word_0_i,
  input  pcmd_pkg::word_t word_1_i,
  input  pcmd_pkg::word_t word_2_i,
  input  pcmd_pkg::word_t word_3_i,
  input  pcmd_pkg::word_t word_4_i,
  input  pcmd_pkg::word_t word_5_i,
  input  pcmd_pkg::word_t word_6_i,
  input  pcmd_pkg::word_t word_7_i,
  input  logic            padding_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pcmd_pkg::word_t out_0_o,
  output pcmd_pkg::word_t out_1_o,
  output pcmd_pkg::word_t out_2_o,
  output pcmd_pkg::word_t out_3_o,
  output pcmd_pkg::word_t out_4_o,
  output pcmd_pkg::word_t out_5_o,
  output pcmd_pkg::word_t out_6_o,
  output pcmd_pkg::word_t out_7_o
);
  import pcmd_pkg::*;

  word_t      raw_words [Columns];
  word_t      in_words  [Columns];
  word_t      lane_words[Columns];
  word_t      pass_q;
  word_t      out_q     [Columns];
  cnt_t       fill_q, fill_d;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic       out_free;
  logic       s1_move;
  logic       in_accept;
  lane_ctrl_t lane_ctrl;

  assign raw_words[0] = word_0_i;
  assign raw_words[1] = word_1_i;
  assign raw_words[2] = word_2_i;
  assign raw_words[3] = word_3_i;
  assign raw_words[4] = word_4_i;
  assign raw_words[5] = word_5_i;
  assign raw_words[6] = word_6_i;
  assign raw_words[7] = word_7_i;

  // padding lines push zeros
  always_comb begin
    for (int c = 0; c < Columns; c++) begin
      in_words[c] = padding_i ? '0 : raw_words[c];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // count lines up to the longest delay, then hold
  assign fill_d = (fill_q == CntW'(MaxDelay)) ? fill_q : fill_q + CntW'(1);

  assign lane_ctrl.accept = in_accept;
  assign lane_ctrl.fill   = fill_q;

  for (genvar c = 0; c < Columns - 1; c++) begin : g_lane
    pcmd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .depth_i (lane_depth(c)),
      .word_i  (in_words[c]),
      .word_o  (lane_words[c])
    );
  end

  // last column has no delay: register it alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pass_q <= in_words[Columns-1];
    end
  end
  assign lane_words[Columns-1] = pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        fill_q <= fill_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // merge the lanes into the output register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      for (int c = 0; c < Columns; c++) begin
        out_q[c] <= lane_words[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_0_o     = out_q[0];
  assign out_1_o     = out_q[1];
  assign out_2_o     = out_q[2];
  assign out_3_o     = out_q[3];
  assign out_4_o     = out_q[4];
  assign out_5_o     = out_q[5];
  assign out_6_o     = out_q[6];
  assign out_7_o     = out_q[7];

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MaxDelay))
    else $error("fill count beyond longest delay");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item lost before read stage");

  a_s1_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("read stage item lost before output");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q)
    else $error("read stage dropped while output stalled");
`endif

endmodule

>>> src/pcmd_ram.sv
// Generic single-port RAM with registered read; a read returns the old word
// when the same address is written in that cycle. No dependencies.
module pcmd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pcmd_lane.sv
// One delay lane of the deinterleaver: a ring in a pcmd_ram and its pointer.
// Depends on pcmd_pkg and pcmd_ram.
module pcmd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcmd_pkg::lane_ctrl_t ctrl_i,
  input  pcmd_pkg::cnt_t      depth_i,
  input  pcmd_pkg::word_t     word_i,
  output pcmd_pkg::word_t     word_o
);
  import pcmd_pkg::*;

  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             filled_q;
  word_t            rdata;

  // wrap at the lane's own delay length
  assign ptr_d = (ptr_q == AddrW'(depth_i - CntW'(1))) ? '0 : ptr_q + AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      filled_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      ptr_q    <= ptr_d;
      // entries not yet written since reset read as zero
      filled_q <= (ctrl_i.fill >= depth_i);
    end
  end

  pcmd_ram #(
    .Width (WordBits),
    .Depth (MaxDelay)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept),
    .re_i    (ctrl_i.accept),
    .addr_i  (ptr_q),
    .wdata_i (word_i),
    .rdata_o (rdata)
  );

  assign word_o = filled_q ? rdata : '0;

endmodule
